>>> rtl/core/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: widths, constants and shared types.
// Used by the divider unit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CHAN_W       = 8;
    localparam int HUE_W        = 15;
    localparam int SAT_W        = 13;
    localparam int VAL_W        = 13;
    localparam int FRAC_BITS_DF = 6;

    // Hue sector of the largest channel.
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

endpackage

>>> rtl/core/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter.
// Depends on rgbhsv_pkg and rgbhsv_div.
`timescale 1ns / 1ps

// One pixel may be started in every cycle; busy is never raised, and the
// receiver cannot stall. The result reaches the o_ ports with o_done high through
// 2 front stages, the hue divider's capture stage and its FRAC_BITS + 17
// bit-per-stage steps, then one output register. Throughput is one pixel per clock.
module rgb_to_hsv_converter_top #(
    parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_blue,
    output logic                          o_done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]  o_saturation,
    output logic [rgbhsv_pkg::VAL_W-1:0]  o_brightness,
    output logic                          o_achromatic
);
    import rgbhsv_pkg::*;

    // Hue numerator: 60*diff + base*d < 480*255, 17 bits, shifted by FRAC_BITS.
    localparam int HN_W  = 17 + FRAC_BITS;
    // Saturation numerator: 100*d < 2^15, shifted by FRAC_BITS.
    localparam int SN_W  = 15 + FRAC_BITS;
    // Value product: max * 100 * 2^F, then times a reciprocal of 255.
    localparam int VP_W  = 15 + FRAC_BITS;
    localparam int DLY   = HN_W - SN_W;
    localparam int HMAX_W = 9 + FRAC_BITS + 1;
    localparam logic [HMAX_W-1:0] HUE_WRAP = HMAX_W'(360) << FRAC_BITS;
    // Reciprocal of 255 scaled by 2^VK, rounded down; the estimate is low by at most one.
    localparam int VK    = VP_W + 8;
    localparam int VPR_W = VP_W + VK - 7;
    localparam longint unsigned VRECIP = (64'd1 << VK) / 64'd255;
    localparam logic [VPR_W-1:0] VRECIP100 = VPR_W'(VRECIP * 64'd100);

    assign busy = 1'b0;

    // Stage 1: extremes and sector.
    logic             r_v1;
    logic [CHAN_W-1:0] r_r1, r_g1, r_b1, r_mx1, r_mn1;
    t_sector          r_sec1;
    logic [CHAN_W-1:0] n_mx, n_mn;
    t_sector          n_sec;

    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        priority if (n_mx == i_red) n_sec = SEC_RED;
        else if (n_mx == i_green) n_sec = SEC_GREEN;
        else n_sec = SEC_BLUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_r1 <= i_red; r_g1 <= i_green; r_b1 <= i_blue;
        r_mx1 <= n_mx; r_mn1 <= n_mn; r_sec1 <= n_sec;
    end

    // Stage 2: numerators, value product and the value quotient estimate.
    logic [CHAN_W-1:0] n_d, n_pos, n_neg;
    logic [8:0]        n_base;
    logic [16:0]       n_hnum;
    logic [VPR_W-1:0]  n_vprod;
    logic              r_v2;
    logic [HN_W-1:0]   r_hnum2;
    logic [SN_W-1:0]   r_snum2;
    logic [CHAN_W-1:0] r_d2, r_mx2;
    logic [VP_W-1:0]   r_vp2;
    logic [VP_W-1:0]   r_vq2;

    always_comb begin
        n_d = r_mx1 - r_mn1;
        unique case (r_sec1)
            SEC_RED:   begin n_pos = r_g1; n_neg = r_b1; n_base = 9'd360; end
            SEC_GREEN: begin n_pos = r_b1; n_neg = r_r1; n_base = 9'd120; end
            default:   begin n_pos = r_r1; n_neg = r_g1; n_base = 9'd240; end
        endcase
        n_hnum = 17'(17'd60 * n_pos) + (17'(n_base) * 17'(n_d)) - 17'(17'd60 * n_neg);
        n_vprod = (VPR_W'(r_mx1) * VRECIP100) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_hnum2 <= HN_W'(n_hnum) << FRAC_BITS;
        r_snum2 <= SN_W'(15'(15'd100 * n_d)) << FRAC_BITS;
        r_d2    <= n_d;
        r_mx2   <= r_mx1;
        r_vp2   <= VP_W'(15'(15'd100 * r_mx1)) << FRAC_BITS;
        r_vq2   <= VP_W'(n_vprod >> VK);
    end

    // Value: the reciprocal estimate is exact or one low, so one remainder check fixes it.
    logic [VP_W-1:0] n_vrem;
    logic [VP_W-1:0] n_vq;
    always_comb begin
        n_vrem = r_vp2 - ((r_vq2 << 8) - r_vq2);
        n_vq   = (n_vrem >= VP_W'(255)) ? r_vq2 + VP_W'(1) : r_vq2;
    end

    // Dividers: the hue tag carries the value and the grey flag, the saturation
    // tag carries the black flag.
    localparam int TAG_W = VAL_W + 1;
    logic              h_v, s_v;
    logic [HN_W-1:0]   h_q;
    logic [SN_W-1:0]   s_q;
    logic              s_zero;
    logic [TAG_W-1:0]  h_tag_unused;
    logic [CHAN_W-1:0] n_sden;

    assign n_sden = (r_mx2 == '0) ? CHAN_W'(1) : r_mx2;

    rgbhsv_div #(.NUM_W(HN_W), .DEN_W(CHAN_W), .TAG_W(TAG_W)) u_hue_div (
        .i_clk, .i_rst_n, .i_valid(r_v2), .i_num(r_hnum2),
        .i_den((r_d2 == '0) ? CHAN_W'(1) : r_d2),
        .i_tag({(r_d2 == '0), VAL_W'(n_vq)}),
        .o_valid(h_v), .o_quot(h_q), .o_tag(h_tag_unused)
    );

    rgbhsv_div #(.NUM_W(SN_W), .DEN_W(CHAN_W), .TAG_W(1)) u_sat_div (
        .i_clk, .i_rst_n, .i_valid(r_v2), .i_num(r_snum2), .i_den(n_sden),
        .i_tag(r_mx2 == '0),
        .o_valid(s_v), .o_quot(s_q), .o_tag(s_zero)
    );

    // Align saturation with the deeper hue divider.
    logic            r_sv [DLY+1];
    logic            r_sz [DLY+1];
    logic [SN_W-1:0] r_sq [DLY+1];
    always_comb begin
        r_sv[0] = s_v;
        r_sz[0] = s_zero;
        r_sq[0] = s_q;
    end
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
            if (r_sv[k]) begin
                r_sq[k+1] <= r_sq[k];
                r_sz[k+1] <= r_sz[k];
            end
        end
    end

    // Output register: wrap hue, zero special cases.
    logic [HN_W-1:0] n_hue;
    always_comb begin
        n_hue = h_q;
        if (h_tag_unused[TAG_W-1]) n_hue = '0;
        else if (n_hue >= HN_W'(HUE_WRAP)) n_hue = n_hue - HN_W'(HUE_WRAP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= h_v & r_sv[DLY];
        end
        o_hue        <= HUE_W'(n_hue);
        o_saturation <= r_sz[DLY] ? '0 : SAT_W'(r_sq[DLY]);
        o_brightness <= h_tag_unused[VAL_W-1:0];
        o_achromatic <= h_tag_unused[TAG_W-1];
    end

endmodule

>>> rtl/core/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rgbhsv_pkg; used by the top level for hue and saturation.
`timescale 1ns / 1ps

module rgbhsv_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    import rgbhsv_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic             r_vld [NUM_W+1];
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [REM_W-1:0] r_rem [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    // Stage zero captures the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_rem[0] <= '0;
        r_tag[0] <= i_tag;
    end

    // Each stage brings down one numerator bit and tries one subtraction.
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [REM_W-1:0] n_trial;
        logic [REM_W-1:0] n_rem;
        logic             n_bit;
        always_comb begin
            n_trial = {r_rem[k][DEN_W-1:0], r_num[k][NUM_W-1]};
            n_bit   = (n_trial >= {1'b0, r_den[k]});
            n_rem   = n_bit ? (n_trial - {1'b0, r_den[k]}) : n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_num[k+1] <= {r_num[k][NUM_W-2:0], n_bit};
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= n_rem;
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule

>>> rtl/core/rgbhsv_chk.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rgbhsv_pkg for field widths.
`timescale 1ns / 1ps

module rgbhsv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_done,
    input logic [14:0] o_hue,
    input logic [12:0] o_saturation,
    input logic [12:0] o_brightness,
    input logic        o_achromatic
);
    import rgbhsv_pkg::*;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hue < 15'd23040)) else $error("hue out of range");
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_saturation <= 13'd6400)) else $error("saturation out of range");
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_achromatic) |-> (o_hue == '0 && o_saturation == '0))
        else $error("grey pixel with nonzero hue or saturation");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

endmodule

bind rgb_to_hsv_converter_top rgbhsv_chk u_chk (.*);

>>> tb/sv/rgb_to_hsv_converter_top_tb.sv
// Testbench for the RGB to HSV converter top level.
// Drives pixels through the start/busy command interface and checks every result
// against a behavioral HSV calculation; depends on rgbhsv_pkg and the RTL only.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

    import rgbhsv_pkg::*;

    localparam int FRAC    = FRAC_BITS_DF;
    localparam int LATENCY = FRAC + 16 + 4;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
        logic             grey;
    } t_hsv;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CHAN_W-1:0] i_red;
    logic [CHAN_W-1:0] i_green;
    logic [CHAN_W-1:0] i_blue;
    logic              o_done;
    logic [HUE_W-1:0]  o_hue;
    logic [SAT_W-1:0]  o_saturation;
    logic [VAL_W-1:0]  o_brightness;
    logic              o_achromatic;

    t_hsv        hsv_pending[$];
    int unsigned mismatch_cnt;
    int unsigned pixel_cnt;
    int unsigned result_cnt;
    int unsigned idle_pct;

    rgb_to_hsv_converter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness),
        .o_achromatic (o_achromatic)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Exact HSV of one pixel, each field truncated to FRAC fraction bits.
    function automatic t_hsv hsv_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        t_hsv        res;
        longint      mx, mn, d, num, q, scale;
        t_sector     sec;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d     = mx - mn;
        scale = longint'(1) << FRAC;
        // Ties go to red first, then green.
        if (mx == r)      sec = SEC_RED;
        else if (mx == g) sec = SEC_GREEN;
        else              sec = SEC_BLUE;
        q = 0;
        if (d != 0) begin
            case (sec)
                SEC_RED:   num = 60 * (longint'(g) - longint'(b)) + 360 * d;
                SEC_GREEN: num = 60 * (longint'(b) - longint'(r)) + 120 * d;
                default:   num = 60 * (longint'(r) - longint'(g)) + 240 * d;
            endcase
            q = (scale * num) / d;
            // The red sector is offset by a full turn, so wrap it back.
            if (q >= 360 * scale) q -= 360 * scale;
        end
        res.hue  = q[HUE_W-1:0];
        res.sat  = (mx == 0) ? '0 : SAT_W'((scale * 100 * d) / mx);
        res.val  = VAL_W'((scale * 100 * mx) / 255);
        res.grey = (d == 0);
        return res;
    endfunction

    // Sends one pixel after an optional random gap and waits for its transfer.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        hsv_pending.push_back(hsv_of_pixel(r, g, b));
        pixel_cnt++;
    endtask

    // Lowers start once the stream stops.
    task automatic go_quiet();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result checker: every strobed result is matched with the oldest pixel.
    always @(posedge i_clk) begin
        t_hsv exp_hsv;
        if (i_rst_n && o_done) begin
            result_cnt++;
            if (hsv_pending.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: result with no pixel pending, hue %0d", o_hue);
            end else begin
                exp_hsv = hsv_pending.pop_front();
                if (o_hue !== exp_hsv.hue || o_saturation !== exp_hsv.sat ||
                    o_brightness !== exp_hsv.val || o_achromatic !== exp_hsv.grey) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: hsv exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_hsv.hue, exp_hsv.sat, exp_hsv.val, exp_hsv.grey,
                                 o_hue, o_saturation, o_brightness, o_achromatic);
                end
            end
        end
    end

    // Extremes, greys, ties and each hue sector including the red wrap.
    task automatic test_directed_pixels();
        idle_pct = 0;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd10, 8'd200, 8'd10);
        send_pixel(8'd55, 8'd170, 8'd170);
        send_pixel(8'hAA, 8'h55, 8'hFF);
        go_quiet();
    endtask

    // Random pixels under one idling setting; ties are forced now and then.
    task automatic test_random_pixels(input int unsigned count, input int unsigned pct);
        logic [7:0] r, g, b;
        idle_pct = pct;
        repeat (count) begin
            r = $urandom_range(255, 0);
            g = $urandom_range(255, 0);
            b = $urandom_range(255, 0);
            case ($urandom_range(7, 0))
                0: g = r;
                1: b = g;
                2: b = r;
                3: begin g = r; b = r; end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        go_quiet();
    endtask

    // Stimulus sequence.
    initial begin
        mismatch_cnt = 0;
        pixel_cnt    = 0;
        result_cnt   = 0;
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_red        = '0;
        i_green      = '0;
        i_blue       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_pixels();
        test_random_pixels(300, 0);
        test_random_pixels(250, 76);
        test_random_pixels(300, 7);
        while (hsv_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d pixels (directed edges, ties, greys, random) and checked %0d results.",
                 pixel_cnt, result_cnt);
        if (mismatch_cnt == 0 && hsv_pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
